/* hw/rtl/quickhull_line_partition_top_assert.svh */
// Assertion macros for the quickhull line partition block.
// Used by quickhull_line_partition_top; expects clk_i and rst_ni in scope.
`ifndef QUICKHULL_LINE_PARTITION_TOP_ASSERT_SVH
`define QUICKHULL_LINE_PARTITION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define QLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quickhull partition: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define QLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quickhull partition: next-cycle check failed");

`endif

/* hw/rtl/qlp_pkg.sv */
// Types and constants shared by the quickhull line partition modules.
// No dependencies.
package qlp_pkg;

  localparam int unsigned COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  // one bit of headroom for coordinate differences
  typedef logic signed [COORD_BITS:0]     diff_t;
  // exact product of two differences
  typedef logic signed [2*COORD_BITS+1:0] prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   is_upper;
    coord_t left_x;
    coord_t left_y;
    coord_t right_x;
    coord_t right_y;
    logic   points_dropped;
    logic   end_of_set;
  } out_t;

  // set descriptor handed from the loader to the emitter
  typedef struct packed {
    point_t left;
    point_t right;
    logic   dropped;
    logic   bank;
  } desc_t;

endpackage

/* hw/rtl/qlp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qlp_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 128,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/qlp_front.sv */
// Loader: takes points, writes them to the point store and tracks the
// extreme points; hands a set descriptor to the emitter. Uses qlp_pkg.
module qlp_front import qlp_pkg::*; #(
  parameter  int unsigned MAX_POINTS = 64,
  localparam int unsigned CW         = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  in_t           item_i,
  output logic          ram_we_o,
  output logic [AW:0]   ram_waddr_o,
  output point_t        ram_wdata_o,
  output logic          desc_valid_o,
  output desc_t         desc_o,
  output logic [CW-1:0] desc_count_o,
  input  logic          desc_pop_i
);

  logic [CW-1:0] cnt_q, cnt_inc;
  point_t        left_q, left_d, right_q, right_d, pt;
  logic          ovf_q, bank_q;
  logic          desc_valid_q;
  desc_t         desc_q;
  logic [CW-1:0] desc_count_q;
  logic          accept, has_room, store, ovf_set;

  assign accept   = push_i & ~full_o;
  assign has_room = cnt_q < CW'(MAX_POINTS);
  assign store    = accept & has_room;
  assign ovf_set  = accept & ~has_room;
  assign cnt_inc  = CW'(cnt_q + 1'b1);
  assign pt.x     = item_i.point_x;
  assign pt.y     = item_i.point_y;

  // write the point into the loader's bank
  assign ram_we_o    = store;
  assign ram_waddr_o = {bank_q, cnt_q[AW-1:0]};
  assign ram_wdata_o = pt;

  // update the extreme points; the earlier point wins a tie in x
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (store) begin
      if (cnt_q == '0) begin
        left_d  = pt;
        right_d = pt;
      end else begin
        if (pt.x < left_q.x) begin
          left_d = pt;
        end
        if (pt.x > right_q.x) begin
          right_d = pt;
        end
      end
    end
  end

  // hold the set state; close the set on its last point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      left_q       <= '0;
      right_q      <= '0;
      ovf_q        <= 1'b0;
      bank_q       <= 1'b0;
      desc_valid_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      if (accept && item_i.last_point) begin
        cnt_q        <= '0;
        ovf_q        <= 1'b0;
        bank_q       <= ~bank_q;
        desc_valid_q <= 1'b1;
      end else begin
        if (store) begin
          cnt_q <= cnt_inc;
        end
        if (ovf_set) begin
          ovf_q <= 1'b1;
        end
        if (desc_pop_i) begin
          desc_valid_q <= 1'b0;
        end
      end
    end
  end

  // descriptor payload
  always_ff @(posedge clk_i) begin
    if (accept && item_i.last_point) begin
      desc_q.left    <= left_d;
      desc_q.right   <= right_d;
      desc_q.dropped <= ovf_q | ovf_set;
      desc_q.bank    <= bank_q;
      desc_count_q   <= store ? cnt_inc : cnt_q;
    end
  end

  // a queued set owns the other bank, so stall until it is taken
  assign full_o       = desc_valid_q;
  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;
  assign desc_count_o = desc_count_q;

endmodule

/* hw/rtl/qlp_back.sv */
// Emitter: reads a stored set back, classifies each point against the
// left-right line and queues the results. Uses qlp_pkg.
module qlp_back import qlp_pkg::*; #(
  parameter  int unsigned MAX_POINTS = 64,
  localparam int unsigned CW         = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          desc_valid_i,
  input  desc_t         desc_i,
  input  logic [CW-1:0] desc_count_i,
  output logic          desc_pop_o,
  output logic          ram_re_o,
  output logic [AW:0]   ram_raddr_o,
  input  point_t        ram_rdata_i,
  input  logic          pop_i,
  output logic          empty_o,
  output out_t          result_o
);

  localparam int unsigned FD  = 8;
  localparam int unsigned FAW = $clog2(FD);
  localparam int unsigned FCW = FAW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] idx_q, cnt_q, idx_inc;
  desc_t         cur_q;
  diff_t         abx_q, aby_q;

  logic          v1_q, e1_q;
  logic          v2_q, e2_q;
  point_t        pt2_q;
  diff_t         acx_q, acy_q;
  logic          v3_q, e3_q;
  point_t        pt3_q;
  prod_t         p1_q, p2_q;

  out_t           fifo_q [FD];
  logic [FAW-1:0] wp_q, rp_q;
  logic [FCW-1:0] fcnt_q, inflight;
  logic           credit_ok, issue, take, fpush, fpop, idx_last;
  out_t           res;

  assign inflight  = FCW'(v1_q) + FCW'(v2_q) + FCW'(v3_q);
  assign credit_ok = (fcnt_q + inflight) < FCW'(FD);
  assign take      = (state_q == ST_IDLE) & desc_valid_i;
  assign issue     = (state_q == ST_RUN) & credit_ok;
  assign idx_inc   = CW'(idx_q + 1'b1);
  assign idx_last  = idx_inc == cnt_q;

  assign desc_pop_o  = take;
  assign ram_re_o    = issue;
  assign ram_raddr_o = {cur_q.bank, idx_q[AW-1:0]};

  // sequence one set: take it, issue its reads, wait for the pipe to empty
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (desc_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_inc;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // latch the set and the line direction
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= desc_i;
      cnt_q <= desc_count_i;
      abx_q <= diff_t'($signed(desc_i.right.x)) - diff_t'($signed(desc_i.left.x));
      aby_q <= diff_t'($signed(desc_i.right.y)) - diff_t'($signed(desc_i.left.y));
    end
  end

  // pipeline: read, offset from the left point, products
  always_ff @(posedge clk_i) begin
    e1_q  <= issue & idx_last;
    e2_q  <= e1_q;
    pt2_q <= ram_rdata_i;
    acx_q <= diff_t'($signed(ram_rdata_i.x)) - diff_t'($signed(cur_q.left.x));
    acy_q <= diff_t'($signed(ram_rdata_i.y)) - diff_t'($signed(cur_q.left.y));
    e3_q  <= e2_q;
    pt3_q <= pt2_q;
    p1_q  <= prod_t'(abx_q) * prod_t'(acy_q);
    p2_q  <= prod_t'(aby_q) * prod_t'(acx_q);
  end

  // assemble the result; strictly positive cross product is the upper side
  always_comb begin
    res.out_x          = pt3_q.x;
    res.out_y          = pt3_q.y;
    res.is_upper       = p1_q > p2_q;
    res.left_x         = cur_q.left.x;
    res.left_y         = cur_q.left.y;
    res.right_x        = cur_q.right.x;
    res.right_y        = cur_q.right.y;
    res.points_dropped = cur_q.dropped;
    res.end_of_set     = e3_q;
  end

  // result queue
  assign fpush = v3_q;
  assign fpop  = pop_i & (fcnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fcnt_q <= '0;
    end else begin
      if (fpush) begin
        wp_q <= FAW'(wp_q + 1'b1);
      end
      if (fpop) begin
        rp_q <= FAW'(rp_q + 1'b1);
      end
      if (fpush && !fpop) begin
        fcnt_q <= FCW'(fcnt_q + 1'b1);
      end else if (fpop && !fpush) begin
        fcnt_q <= FCW'(fcnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fpush) begin
      fifo_q[wp_q] <= res;
    end
  end

  assign empty_o  = fcnt_q == '0;
  assign result_o = fifo_q[rp_q];

endmodule

/* hw/rtl/quickhull_line_partition_top.sv */
// Quickhull initial partition: loads a point set, then emits each point
// with its side of the leftmost-to-rightmost line.
// Depends on qlp_pkg, qlp_ram, qlp_front, qlp_back and the assertion header.
//
// Input channel: push/full with item_i (point_x, point_y, last_point).
// A point is taken on each cycle with push high and full low. The set
// closes on the point marked last_point.
// Result channel: empty/pop with result_o. One result per stored point,
// in load order, each carrying the set's leftmost and rightmost points, the
// dropped flag and end_of_set on the final one.
// With the emitter idle, the first result of a set passes the descriptor,
// the read, offset and product stages and the result queue; results then
// follow one per cycle while the queue has room, the rate being set by the
// single read port of the point store and the eight-entry result queue.
// The store has two banks, so the next set loads while the previous one is
// emitted; full rises after every last point is taken and stays high while
// a closed set is waiting for the emitter.
// When the receiver stalls, the result queue fills and emission pauses;
// loading continues until a second set is closed.
// Reset empties both queues and clears the point count; the store itself
// is not cleared. Points beyond MAX_POINTS in one set are dropped and flagged.
`include "quickhull_line_partition_top_assert.svh"

module quickhull_line_partition_top import qlp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  item_i,
  input  logic pop,
  output logic empty,
  output out_t result_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic          ram_we, ram_re;
  logic [AW:0]   ram_waddr, ram_raddr;
  point_t        ram_wdata, ram_rdata;
  logic          desc_valid, desc_pop;
  desc_t         desc;
  logic [CW-1:0] desc_count;

  // loader
  qlp_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .desc_valid_o(desc_valid),
    .desc_o      (desc),
    .desc_count_o(desc_count),
    .desc_pop_i  (desc_pop)
  );

  // point store, two banks of MAX_POINTS rounded up to a power of two
  qlp_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(2 * (2 ** AW))
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // emitter
  qlp_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(desc_valid),
    .desc_i      (desc),
    .desc_count_i(desc_count),
    .desc_pop_o  (desc_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

  // loader and emitter never touch the same bank in one cycle
  `QLP_ASSERT_SAME(a_bank_split, ram_we && ram_re, ram_waddr[AW] != ram_raddr[AW])
  // a closed set is queued for the emitter on the next cycle
  `QLP_ASSERT_NEXT(a_set_queued, push && !full && item_i.last_point, desc_valid)
  // the emitter only takes a set that is waiting
  `QLP_ASSERT_SAME(a_pop_valid, desc_pop, desc_valid)

endmodule

/* sim/tb_quickhull_line_partition_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quickhull_line_partition_top: loads point sets
// and checks every emitted point and its side flag against a local predictor.
// Depends on qlp_pkg and the RTL of the block.
module tb_quickhull_line_partition_top;
  import qlp_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_PRINTED = 50;

  typedef enum int {
    STYLE_WIDE,
    STYLE_GRID,
    STYLE_LINE,
    STYLE_EDGE
  } coord_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t  item_i = '0;
  logic pop = 1'b0;
  logic empty;
  out_t result_o;

  // predictor state for the set being loaded
  point_t loaded_points[$];
  point_t part_left;
  point_t part_right;
  bit     part_dropped;
  out_t   expected_partition[$];

  int push_gap_pct = 0;
  int pop_gap_pct = 0;
  int pop_hold_cycles = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  quickhull_line_partition_top #(
    .MAX_POINTS(STORE_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .pop     (pop),
    .empty   (empty),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  // abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_error(string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // true when (right - left) x (p - left) is strictly positive, computed exactly
  function automatic bit above_line(point_t p);
    longint lx, ly, rx, ry, px, py;
    lx = $signed(part_left.x);
    ly = $signed(part_left.y);
    rx = $signed(part_right.x);
    ry = $signed(part_right.y);
    px = $signed(p.x);
    py = $signed(p.y);
    return ((rx - lx) * (py - ly) - (ry - ry + ry - ly) * (px - lx)) > 0;
  endfunction

  // take one accepted point into the set; on the last one, queue the partition
  function automatic void classify_point(in_t pt);
    point_t p;
    out_t   r;
    p.x = pt.point_x;
    p.y = pt.point_y;
    if (loaded_points.size() < STORE_DEPTH) begin
      if (loaded_points.size() == 0) begin
        part_left  = p;
        part_right = p;
      end else begin
        // ties keep the earlier point
        if ($signed(p.x) < $signed(part_left.x)) part_left = p;
        if ($signed(p.x) > $signed(part_right.x)) part_right = p;
      end
      loaded_points.insert(loaded_points.size(), p);
    end else begin
      part_dropped = 1'b1;
    end
    if (!pt.last_point) return;
    foreach (loaded_points[k]) begin
      r.out_x          = loaded_points[k].x;
      r.out_y          = loaded_points[k].y;
      r.is_upper       = above_line(loaded_points[k]);
      r.left_x         = part_left.x;
      r.left_y         = part_left.y;
      r.right_x        = part_right.x;
      r.right_y        = part_right.y;
      r.points_dropped = part_dropped;
      r.end_of_set     = (k == loaded_points.size() - 1);
      expected_partition.insert(expected_partition.size(), r);
    end
    loaded_points.delete();
    part_dropped = 1'b0;
  endfunction

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task automatic check_partition_result(out_t got);
    out_t want;
    if (expected_partition.size() == 0) begin
      report_error($sformatf("result with nothing expected: x=%h y=%h",
                             got.out_x, got.out_y));
      return;
    end
    want = expected_partition.pop_front();
    check_field("out_x", got.out_x, want.out_x);
    check_field("out_y", got.out_y, want.out_y);
    check_field("is_upper", got.is_upper, want.is_upper);
    check_field("left_x", got.left_x, want.left_x);
    check_field("left_y", got.left_y, want.left_y);
    check_field("right_x", got.right_x, want.right_x);
    check_field("right_y", got.right_y, want.right_y);
    check_field("points_dropped", got.points_dropped, want.points_dropped);
    check_field("end_of_set", got.end_of_set, want.end_of_set);
  endtask

  // take results; hold off pop while a hold count is pending
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_partition_result(result_o);
    if (pop_hold_cycles > 0) begin
      pop_hold_cycles--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_gap_pct);
    end
  end

  function automatic in_t make_point(int x, int y, bit last);
    in_t pt;
    pt.point_x    = x[15:0];
    pt.point_y    = y[15:0];
    pt.last_point = last;
    return pt;
  endfunction

  // offer one request and wait for the handshake, then idle at random
  task automatic push_point(in_t pt);
    push   <= 1'b1;
    item_i <= pt;
    do @(posedge clk_i); while (full);
    classify_point(pt);
    while ($urandom_range(99) < push_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic wait_partition_drained();
    push <= 1'b0;
    while (expected_partition.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int random_coord(coord_style_e style);
    case (style)
      STYLE_GRID: return int'($urandom_range(16)) - 8;
      STYLE_EDGE: begin
        case ($urandom_range(5))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return int'($urandom_range(65535)) - 32768;
        endcase
      end
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic push_random_set(int n, coord_style_e style);
    int x, y;
    for (int k = 0; k < n; k++) begin
      if (style == STYLE_LINE) begin
        // points on y = 2x + 3, so every one is collinear
        x = int'($urandom_range(200)) - 100;
        y = 2 * x + 3;
      end else begin
        x = random_coord(style);
        y = random_coord(style);
      end
      push_point(make_point(x, y, k == n - 1));
    end
  endtask

  task automatic test_directed();
    // single point: left and right coincide
    push_point(make_point(32767, -32768, 1'b1));
    // coordinate extremes, with ties in x at both ends
    push_point(make_point(-32768, 32767, 1'b0));
    push_point(make_point(32767, -32768, 1'b0));
    push_point(make_point(-32768, -32768, 1'b0));
    push_point(make_point(32767, 32767, 1'b0));
    push_point(make_point(0, 0, 1'b1));
    // collinear points go to the lower side; one above, one below
    push_point(make_point(0, 0, 1'b0));
    push_point(make_point(2, 2, 1'b0));
    push_point(make_point(4, 4, 1'b0));
    push_point(make_point(1, 5, 1'b0));
    push_point(make_point(3, -1, 1'b0));
    push_point(make_point(1, 1, 1'b1));
    // same x throughout: everything lower
    push_point(make_point(5, 1, 1'b0));
    push_point(make_point(5, -3, 1'b0));
    push_point(make_point(5, 9, 1'b1));
    // first point starts as both ends, then is displaced as the left end only
    push_point(make_point(100, -50, 1'b0));
    push_point(make_point(-100, 50, 1'b0));
    push_point(make_point(0, 1, 1'b0));
    push_point(make_point(0, -1, 1'b0));
    push_point(make_point(-1, 0, 1'b1));
    wait_partition_drained();
  endtask

  task automatic test_capacity();
    // overfull: dropped points lie far left and must not become leftmost
    for (int k = 0; k < STORE_DEPTH; k++) begin
      push_point(make_point(int'($urandom_range(2000)) - 1000,
                            random_coord(STYLE_WIDE), 1'b0));
    end
    push_point(make_point(-32768, 7, 1'b0));
    push_point(make_point(-32768, -7, 1'b1));
    // dropped flag clears for the next set
    push_random_set(2, STYLE_GRID);
    wait_partition_drained();
  endtask

  task automatic test_random_sets(int n_points);
    int sent;
    int n;
    sent = 0;
    while (sent < n_points) begin
      n = $urandom_range(1, 8);
      push_random_set(n, coord_style_e'($urandom_range(3)));
      sent += n;
    end
    wait_partition_drained();
  endtask

  task automatic test_backpressure();
    // hold the receiver so both banks fill and the input stalls
    pop_hold_cycles = 400;
    for (int s = 0; s < 3; s++) push_random_set(10, STYLE_WIDE);
    wait_partition_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_gap_pct = 8;
    pop_gap_pct  = 88;
    test_directed();
    test_capacity();
    test_random_sets(12);

    push_gap_pct = 88;
    pop_gap_pct  = 8;
    test_random_sets(12);

    push_gap_pct = 0;
    pop_gap_pct  = 0;
    test_random_sets(12);
    test_backpressure();

    repeat (20) @(posedge clk_i);
    if (expected_partition.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_partition.size()));
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/qlp_pkg.sv
hw/rtl/qlp_ram.sv
hw/rtl/qlp_front.sv
hw/rtl/qlp_back.sv
hw/rtl/quickhull_line_partition_top.sv
sim/tb_quickhull_line_partition_top.sv
